### design/rls_pkg.sv
// ---------------------------------------------------------------------------
// rls_pkg: shared types and constants for the RLS two-parameter estimator
// Word type, register map, reset values, sequencer states, saturating helpers.
// ---------------------------------------------------------------------------
package rls_pkg;

    localparam int WORD_W     = 64;
    localparam int DIGIT_W    = 8;
    localparam int MUL_STEPS  = WORD_W / DIGIT_W;
    localparam int DIV_STEPS  = WORD_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FF_W       = 17;
    localparam int A_W        = 19;
    localparam int B_W        = 21;
    localparam int COVI_W     = 31;
    localparam int ERR_W      = 32;
    localparam int COV_W      = 32;
    localparam int LAMBDA_FRAC = 16;

    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_FRAC_BITS    = 16;

    localparam logic [FF_W-1:0]   RST_FF   = 17'd65208;
    localparam logic [A_W-1:0]    RST_IA   = 19'd52429;
    localparam logic [B_W-1:0]    RST_IB   = 21'd13107;
    localparam logic [COVI_W-1:0] RST_IC   = 31'd32768000;
    localparam logic [A_W-1:0]    RST_ALO  = 19'd45875;
    localparam logic [A_W-1:0]    RST_AHI  = 19'd85197;
    localparam logic [B_W-1:0]    RST_BLO  = 21'd0;
    localparam logic [B_W-1:0]    RST_BHI  = 21'd196608;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORGET = 3'd0,
        CFG_INIT_A = 3'd1,
        CFG_INIT_B = 3'd2,
        CFG_INIT_C = 3'd3,
        CFG_A_LO   = 3'd4,
        CFG_A_HI   = 3'd5,
        CFG_B_LO   = 3'd6,
        CFG_B_HI   = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_LQ, S_PP0A, S_PP0B, S_PP1A, S_PP1B, S_DA, S_DB,
        S_N0, S_K0, S_N1, S_K1, S_W, S_YA, S_YB, S_EA, S_EB,
        S_C00M, S_C00S, S_C00D, S_C11M, S_C11S, S_C11D,
        S_C01M, S_C01S, S_C01D, S_DONE
    } t_state;

    function automatic t_word sat_add(t_word a, t_word b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? WORD_MIN : WORD_MAX;
        return s[WORD_W-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(t_word a);
        if (a > t_word'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (a < -t_word'(64'sh8000_0000)) return 32'sh8000_0000;
        return a[31:0];
    endfunction

endpackage

### design/rls_two_param_estimator.sv
// ---------------------------------------------------------------------------
// rls_two_param_estimator: 2-parameter RLS estimator with forgetting factor
// Fits speed[k] = a*speed[k-1] + b*drive[k-1] in fixed point.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_ready): one beat carries i_op, i_speed, i_drive.
//    i_op = 1 restarts from the init registers; i_op = 0 is a sample.
//  - Output channel (o_valid / i_ready): exactly one result beat per input beat
//    with the estimates, the prediction error and the primed flag.
//  - Config channel (i_cfg_valid / o_cfg_ready): always ready; write only while
//    the block is idle. init_* values take effect at the next restart.
//  - A restart or priming sample goes straight to the done state, which loads the
//    result register once the output slot is free and then returns to idle.
//  - An update runs 20 multiplies (iterative 8-bit digit multiplier) and 5
//    divides (bit-serial divider) on one shared sequencer, then loads the
//    result register once the output slot is free. o_ready is high only in
//    idle, so one sample is in flight at a time.
//  - Reset loads the register defaults, the starting estimates and covariance
//    and clears the previous sample; the first sample after it only primes.
//  - If the receiver stalls, the finished result holds in the output register;
//    a new beat may still be accepted, and its result waits until the slot
//    frees up.
// ---------------------------------------------------------------------------
module rls_two_param_estimator #(
    parameter int SAMPLE_WIDTH = rls_pkg::DEF_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = rls_pkg::DEF_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_speed,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_drive,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [rls_pkg::A_W-1:0]              o_est_a,
    output logic [rls_pkg::B_W-1:0]              o_est_b,
    output logic signed [rls_pkg::ERR_W-1:0]     o_pred_error,
    output logic                                 o_primed,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rls_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    localparam int W      = rls_pkg::WORD_W;
    localparam int SFRAC  = SAMPLE_WIDTH / 2;
    localparam int W_UP   = (FRAC_BITS >= SFRAC) ? FRAC_BITS - SFRAC : 0;
    localparam int W_DN   = (FRAC_BITS >= SFRAC) ? 0 : SFRAC - FRAC_BITS;
    localparam int A_W    = rls_pkg::A_W;
    localparam int B_W    = rls_pkg::B_W;

    localparam rls_pkg::t_word ONE_F  = rls_pkg::t_word'(1) << FRAC_BITS;
    localparam rls_pkg::t_word ONE_L  = rls_pkg::t_word'(1) << rls_pkg::LAMBDA_FRAC;
    localparam rls_pkg::t_word ONE_W  = rls_pkg::t_word'(1) << W_UP;
    localparam rls_pkg::t_word ONE    = rls_pkg::t_word'(1);

    // config registers
    logic [rls_pkg::FF_W-1:0]   r_ff;
    logic [A_W-1:0]             r_ia, r_alo, r_ahi;
    logic [B_W-1:0]             r_ib, r_blo, r_bhi;
    logic [rls_pkg::COVI_W-1:0] r_ic;

    // estimator state
    logic [A_W-1:0]                  r_tha;
    logic [B_W-1:0]                  r_thb;
    logic signed [rls_pkg::COV_W-1:0] r_c00, r_c01, r_c11;
    logic signed [SAMPLE_WIDTH-1:0]  r_p0, r_p1, r_w, r_u;
    logic                            r_have;

    // working registers
    rls_pkg::t_word r_ta, r_tb, r_pp0, r_pp1, r_den, r_k0, r_k1, r_lamq, r_wf;
    logic signed [rls_pkg::ERR_W-1:0] r_err;
    logic            r_upd, r_issued;

    // output slot
    logic                         r_out_valid, r_out_primed;
    logic [A_W-1:0]               r_out_a;
    logic [B_W-1:0]               r_out_b;
    logic signed [rls_pkg::ERR_W-1:0] r_out_err;

    rls_pkg::t_state r_state, n_state;

    logic           w_accept, w_is_div, w_mul_start, w_div_start;
    logic           w_mul_done, w_div_done, w_done, w_load_out;
    rls_pkg::t_word w_x, w_y, w_mul_p, w_div_q, w_res;
    rls_pkg::t_word w_p0, w_p1, w_ws, w_lam, w_err, w_tha, w_thb;
    rls_pkg::t_word w_c00, w_c01, w_c11, w_sum, w_den, w_yh, w_na, w_nb;

    assign o_ready     = (r_state == rls_pkg::S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign w_p0  = {{(W-SAMPLE_WIDTH){r_p0[SAMPLE_WIDTH-1]}}, r_p0};
    assign w_p1  = {{(W-SAMPLE_WIDTH){r_p1[SAMPLE_WIDTH-1]}}, r_p1};
    assign w_ws  = {{(W-SAMPLE_WIDTH){r_w[SAMPLE_WIDTH-1]}}, r_w};
    assign w_lam = (r_ff == '0) ? ONE : {{(W-rls_pkg::FF_W){1'b0}}, r_ff};
    assign w_err = {{(W-rls_pkg::ERR_W){r_err[rls_pkg::ERR_W-1]}}, r_err};
    assign w_tha = {{(W-A_W){1'b0}}, r_tha};
    assign w_thb = {{(W-B_W){1'b0}}, r_thb};
    assign w_c00 = {{(W-rls_pkg::COV_W){r_c00[rls_pkg::COV_W-1]}}, r_c00};
    assign w_c01 = {{(W-rls_pkg::COV_W){r_c01[rls_pkg::COV_W-1]}}, r_c01};
    assign w_c11 = {{(W-rls_pkg::COV_W){r_c11[rls_pkg::COV_W-1]}}, r_c11};

    // operand select for the shared units
    always_comb begin
        w_x = r_ta;
        w_y = ONE;
        w_is_div = 1'b0;
        unique case (r_state)
            rls_pkg::S_LQ:   begin w_x = w_lam; w_y = ONE_F; end
            rls_pkg::S_PP0A: begin w_x = w_c00; w_y = w_p0;  end
            rls_pkg::S_PP0B: begin w_x = w_c01; w_y = w_p1;  end
            rls_pkg::S_PP1A: begin w_x = w_c01; w_y = w_p0;  end
            rls_pkg::S_PP1B: begin w_x = w_c11; w_y = w_p1;  end
            rls_pkg::S_DA:   begin w_x = w_p0;  w_y = r_pp0; end
            rls_pkg::S_DB:   begin w_x = w_p1;  w_y = r_pp1; end
            rls_pkg::S_N0:   begin w_x = r_pp0; w_y = ONE_F; end
            rls_pkg::S_N1:   begin w_x = r_pp1; w_y = ONE_F; end
            rls_pkg::S_K0, rls_pkg::S_K1: begin
                w_x = r_ta; w_y = r_den; w_is_div = 1'b1;
            end
            rls_pkg::S_W:    begin w_x = w_ws >>> W_DN; w_y = ONE_W; end
            rls_pkg::S_YA:   begin w_x = w_tha; w_y = w_p0;  end
            rls_pkg::S_YB:   begin w_x = w_thb; w_y = w_p1;  end
            rls_pkg::S_EA:   begin w_x = r_k0;  w_y = w_err; end
            rls_pkg::S_EB:   begin w_x = r_k1;  w_y = w_err; end
            rls_pkg::S_C00M: begin w_x = r_k0;  w_y = r_pp0; end
            rls_pkg::S_C11M: begin w_x = r_k1;  w_y = r_pp1; end
            rls_pkg::S_C01M: begin w_x = r_k0;  w_y = r_pp1; end
            rls_pkg::S_C00S, rls_pkg::S_C11S, rls_pkg::S_C01S: begin
                w_x = r_ta; w_y = ONE_L;
            end
            rls_pkg::S_C00D, rls_pkg::S_C11D, rls_pkg::S_C01D: begin
                w_x = r_ta; w_y = w_lam; w_is_div = 1'b1;
            end
            default: begin w_x = r_ta; w_y = ONE; end
        endcase
    end

    logic w_op_state;
    assign w_op_state  = (r_state != rls_pkg::S_IDLE) && (r_state != rls_pkg::S_DONE);
    assign w_mul_start = w_op_state && !r_issued && !w_is_div;
    assign w_div_start = w_op_state && !r_issued && w_is_div;

    rls_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_p)
    );

    rls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (w_x),
        .i_d     (w_y),
        .o_done  (w_div_done),
        .o_quo   (w_div_q)
    );

    assign w_done = r_issued && (w_is_div ? w_div_done : w_mul_done);
    assign w_res  = w_is_div ? w_div_q : w_mul_p;

    // capture helpers
    assign w_sum = rls_pkg::sat_add(r_ta, w_res) >>> SFRAC;
    always_comb begin
        w_den = rls_pkg::sat_add(r_lamq, w_sum);
        if (w_den == '0) w_den = ONE;
    end
    assign w_yh = w_sum;
    always_comb begin
        w_na = rls_pkg::sat_add(w_tha, w_res >>> FRAC_BITS);
        if (w_na < rls_pkg::t_word'({{(W-A_W){1'b0}}, r_alo}))
            w_na = {{(W-A_W){1'b0}}, r_alo};
        if (w_na > rls_pkg::t_word'({{(W-A_W){1'b0}}, r_ahi}))
            w_na = {{(W-A_W){1'b0}}, r_ahi};
        w_nb = rls_pkg::sat_add(w_thb, w_res >>> FRAC_BITS);
        if (w_nb < rls_pkg::t_word'({{(W-B_W){1'b0}}, r_blo}))
            w_nb = {{(W-B_W){1'b0}}, r_blo};
        if (w_nb > rls_pkg::t_word'({{(W-B_W){1'b0}}, r_bhi}))
            w_nb = {{(W-B_W){1'b0}}, r_bhi};
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= rls_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    assign w_load_out = (r_state == rls_pkg::S_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rls_pkg::S_IDLE: begin
                if (w_accept) n_state = (i_op || !r_have) ? rls_pkg::S_DONE : rls_pkg::S_LQ;
            end
            rls_pkg::S_DONE: if (w_load_out) n_state = rls_pkg::S_IDLE;
            rls_pkg::S_LQ:   if (w_done) n_state = rls_pkg::S_PP0A;
            rls_pkg::S_PP0A: if (w_done) n_state = rls_pkg::S_PP0B;
            rls_pkg::S_PP0B: if (w_done) n_state = rls_pkg::S_PP1A;
            rls_pkg::S_PP1A: if (w_done) n_state = rls_pkg::S_PP1B;
            rls_pkg::S_PP1B: if (w_done) n_state = rls_pkg::S_DA;
            rls_pkg::S_DA:   if (w_done) n_state = rls_pkg::S_DB;
            rls_pkg::S_DB:   if (w_done) n_state = rls_pkg::S_N0;
            rls_pkg::S_N0:   if (w_done) n_state = rls_pkg::S_K0;
            rls_pkg::S_K0:   if (w_done) n_state = rls_pkg::S_N1;
            rls_pkg::S_N1:   if (w_done) n_state = rls_pkg::S_K1;
            rls_pkg::S_K1:   if (w_done) n_state = rls_pkg::S_W;
            rls_pkg::S_W:    if (w_done) n_state = rls_pkg::S_YA;
            rls_pkg::S_YA:   if (w_done) n_state = rls_pkg::S_YB;
            rls_pkg::S_YB:   if (w_done) n_state = rls_pkg::S_EA;
            rls_pkg::S_EA:   if (w_done) n_state = rls_pkg::S_EB;
            rls_pkg::S_EB:   if (w_done) n_state = rls_pkg::S_C00M;
            rls_pkg::S_C00M: if (w_done) n_state = rls_pkg::S_C00S;
            rls_pkg::S_C00S: if (w_done) n_state = rls_pkg::S_C00D;
            rls_pkg::S_C00D: if (w_done) n_state = rls_pkg::S_C11M;
            rls_pkg::S_C11M: if (w_done) n_state = rls_pkg::S_C11S;
            rls_pkg::S_C11S: if (w_done) n_state = rls_pkg::S_C11D;
            rls_pkg::S_C11D: if (w_done) n_state = rls_pkg::S_C01M;
            rls_pkg::S_C01M: if (w_done) n_state = rls_pkg::S_C01S;
            rls_pkg::S_C01S: if (w_done) n_state = rls_pkg::S_C01D;
            rls_pkg::S_C01D: if (w_done) n_state = rls_pkg::S_DONE;
            default:         n_state = rls_pkg::S_IDLE;
        endcase
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff  <= rls_pkg::RST_FF;
            r_ia  <= rls_pkg::RST_IA;
            r_ib  <= rls_pkg::RST_IB;
            r_ic  <= rls_pkg::RST_IC;
            r_alo <= rls_pkg::RST_ALO;
            r_ahi <= rls_pkg::RST_AHI;
            r_blo <= rls_pkg::RST_BLO;
            r_bhi <= rls_pkg::RST_BHI;
        end else if (i_cfg_valid) begin
            unique case (rls_pkg::t_cfg_idx'(i_cfg_index))
                rls_pkg::CFG_FORGET: r_ff  <= i_cfg_data[rls_pkg::FF_W-1:0];
                rls_pkg::CFG_INIT_A: r_ia  <= i_cfg_data[A_W-1:0];
                rls_pkg::CFG_INIT_B: r_ib  <= i_cfg_data[B_W-1:0];
                rls_pkg::CFG_INIT_C: r_ic  <= i_cfg_data[rls_pkg::COVI_W-1:0];
                rls_pkg::CFG_A_LO:   r_alo <= i_cfg_data[A_W-1:0];
                rls_pkg::CFG_A_HI:   r_ahi <= i_cfg_data[A_W-1:0];
                rls_pkg::CFG_B_LO:   r_blo <= i_cfg_data[B_W-1:0];
                rls_pkg::CFG_B_HI:   r_bhi <= i_cfg_data[B_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath and estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tha    <= rls_pkg::RST_IA;
            r_thb    <= rls_pkg::RST_IB;
            r_c00    <= {1'b0, rls_pkg::RST_IC};
            r_c01    <= '0;
            r_c11    <= {1'b0, rls_pkg::RST_IC};
            r_p0     <= '0;
            r_p1     <= '0;
            r_have   <= 1'b0;
            r_issued <= 1'b0;
            r_upd    <= 1'b0;
            r_err    <= '0;
        end else begin
            if (w_mul_start || w_div_start) r_issued <= 1'b1;
            if (w_accept) begin
                r_err <= '0;
                r_upd <= 1'b0;
                r_w   <= i_speed;
                r_u   <= i_drive;
                if (i_op) begin
                    // restart: reload from the init registers
                    r_tha  <= r_ia;
                    r_thb  <= r_ib;
                    r_c00  <= {1'b0, r_ic};
                    r_c01  <= '0;
                    r_c11  <= {1'b0, r_ic};
                    r_p0   <= '0;
                    r_p1   <= '0;
                    r_have <= 1'b0;
                end else if (!r_have) begin
                    r_have <= 1'b1;
                    r_p0   <= i_speed;
                    r_p1   <= i_drive;
                end
            end
            if (w_done) begin
                r_issued <= 1'b0;
                unique case (r_state)
                    rls_pkg::S_LQ:   r_lamq <= w_res >>> rls_pkg::LAMBDA_FRAC;
                    rls_pkg::S_PP0B: r_pp0  <= w_sum;
                    rls_pkg::S_PP1B: r_pp1  <= w_sum;
                    rls_pkg::S_DB:   r_den  <= w_den;
                    rls_pkg::S_K0:   r_k0   <= w_res;
                    rls_pkg::S_K1:   r_k1   <= w_res;
                    rls_pkg::S_W:    r_wf   <= w_res;
                    rls_pkg::S_YB:   r_err  <= rls_pkg::sat32(rls_pkg::sat_add(r_wf, -w_yh));
                    rls_pkg::S_EA:   r_tha  <= w_na[A_W-1:0];
                    rls_pkg::S_EB:   r_thb  <= w_nb[B_W-1:0];
                    // covariance correction: p - floor(k*v >> F)
                    rls_pkg::S_C00M:
                        r_ta <= rls_pkg::sat_add(w_c00, -(w_res >>> FRAC_BITS));
                    rls_pkg::S_C11M:
                        r_ta <= rls_pkg::sat_add(w_c11, -(w_res >>> FRAC_BITS));
                    rls_pkg::S_C01M:
                        r_ta <= rls_pkg::sat_add(w_c01, -(w_res >>> FRAC_BITS));
                    rls_pkg::S_C00D: r_c00 <= rls_pkg::sat32(w_res);
                    rls_pkg::S_C11D: r_c11 <= rls_pkg::sat32(w_res);
                    rls_pkg::S_C01D: begin
                        r_c01 <= rls_pkg::sat32(w_res);
                        r_p0  <= r_w;
                        r_p1  <= r_u;
                        r_upd <= 1'b1;
                    end
                    default: r_ta <= w_res;
                endcase
            end
        end
    end

    // output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid  <= 1'b1;
                r_out_a      <= r_tha;
                r_out_b      <= r_thb;
                r_out_err    <= r_err;
                r_out_primed <= r_upd;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_est_a      = r_out_a;
    assign o_est_b      = r_out_b;
    assign o_pred_error = r_out_err;
    assign o_primed     = r_out_primed;
endmodule

### design/rls_mul.sv
// ---------------------------------------------------------------------------
// rls_mul: iterative saturating signed multiplier
// Magnitude product one 8-bit digit per cycle, then sign and 64-bit saturation.
// ---------------------------------------------------------------------------
module rls_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rls_pkg::t_word i_x,
    input  rls_pkg::t_word i_y,
    output logic          o_done,
    output rls_pkg::t_word o_prod
);
    localparam int W  = rls_pkg::WORD_W;
    localparam int D  = rls_pkg::DIGIT_W;
    localparam int CW = $clog2(rls_pkg::MUL_STEPS);

    logic           r_busy, r_fin, r_neg, r_done;
    logic [CW-1:0]  r_cnt;
    logic [2*W-1:0] r_mc, r_acc;
    logic [W-1:0]   r_uy;
    rls_pkg::t_word r_prod;
    logic [W-1:0]   w_ux, w_uy;
    rls_pkg::t_word w_res;

    assign w_ux = i_x[W-1] ? W'(-i_x) : W'(i_x);
    assign w_uy = i_y[W-1] ? W'(-i_y) : W'(i_y);

    always_comb begin
        if (|r_acc[2*W-1:W-1]) begin
            w_res = r_neg ? rls_pkg::WORD_MIN : rls_pkg::WORD_MAX;
        end else begin
            w_res = r_neg ? -rls_pkg::t_word'(r_acc[W-1:0])
                          : rls_pkg::t_word'(r_acc[W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mc   <= {{W{1'b0}}, w_ux};
                r_uy   <= w_uy;
                r_acc  <= '0;
                r_neg  <= i_x[W-1] ^ i_y[W-1];
            end else if (r_busy) begin
                r_acc <= r_acc + r_mc * (2*W)'(r_uy[D-1:0]);
                r_mc  <= r_mc << D;
                r_uy  <= r_uy >> D;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(rls_pkg::MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_prod <= w_res;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

### design/rls_div.sv
// ---------------------------------------------------------------------------
// rls_div: iterative signed divider, truncating toward zero
// Restoring division, one quotient bit per cycle; MIN / -1 gives MAX.
// ---------------------------------------------------------------------------
module rls_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rls_pkg::t_word i_n,
    input  rls_pkg::t_word i_d,
    output logic          o_done,
    output rls_pkg::t_word o_quo
);
    localparam int W  = rls_pkg::WORD_W;
    localparam int CW = $clog2(rls_pkg::DIV_STEPS);

    logic           r_busy, r_fin, r_neg, r_done;
    logic [CW-1:0]  r_cnt;
    logic [W-1:0]   r_q, r_rem, r_ud;
    rls_pkg::t_word r_quo;
    logic [W:0]     w_t, w_diff;

    assign w_t    = {r_rem, r_q[W-1]};
    assign w_diff = w_t - {1'b0, r_ud};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_n[W-1] ? W'(-i_n) : W'(i_n);
                r_ud   <= i_d[W-1] ? W'(-i_d) : W'(i_d);
                r_rem  <= '0;
                r_neg  <= i_n[W-1] ^ i_d[W-1];
            end else if (r_busy) begin
                if (!w_diff[W]) begin
                    r_rem <= w_diff[W-1:0];
                    r_q   <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_t[W-1:0];
                    r_q   <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(rls_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                if (r_neg)            r_quo <= -rls_pkg::t_word'(r_q);
                else if (r_q[W-1])    r_quo <= rls_pkg::WORD_MAX;
                else                  r_quo <= rls_pkg::t_word'(r_q);
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

### test/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for rls_two_param_estimator
// Drives sample/restart beats and register writes, predicts every result
// beat with a 64-bit fixed-point model of the RLS update, and compares fields.
// ---------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 40000;  // idle cycles

    typedef struct packed {
        logic [rls_pkg::A_W-1:0]          est_a;
        logic [rls_pkg::B_W-1:0]          est_b;
        logic signed [rls_pkg::ERR_W-1:0] err;
        logic                             primed;
    } t_est_beat;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic                             i_op;
    logic signed [15:0]               i_speed;
    logic signed [15:0]               i_drive;
    logic                             o_valid;
    logic                             i_ready;
    logic [rls_pkg::A_W-1:0]          o_est_a;
    logic [rls_pkg::B_W-1:0]          o_est_b;
    logic signed [rls_pkg::ERR_W-1:0] o_pred_error;
    logic                             o_primed;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [rls_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [rls_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    // model copy of the register file
    logic [rls_pkg::FF_W-1:0]   m_forget;
    logic [rls_pkg::A_W-1:0]    m_init_a, m_a_lo, m_a_hi;
    logic [rls_pkg::B_W-1:0]    m_init_b, m_b_lo, m_b_hi;
    logic [rls_pkg::COVI_W-1:0] m_init_cov;

    // model copy of the estimator state
    logic signed [63:0] th_a, th_b, p00, p01, p11, last_speed, last_drive;
    logic               primed_ok;

    t_est_beat expected_q[$];
    int tx_idle_pct, rx_idle_pct;
    int mismatches, beats_checked, samples_sent, restarts_sent, updates_seen;
    int stall_cycles;

    rls_two_param_estimator dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---- fixed-point helpers (64-bit, saturating) ----
    function automatic logic signed [63:0] s_add(logic signed [63:0] x,
                                                 logic signed [63:0] y);
        logic signed [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] s_mul(logic signed [63:0] x,
                                                 logic signed [63:0] y);
        logic signed [127:0] xe, ye, p;
        xe = x;
        ye = y;
        p = xe * ye;
        if (p[127:63] != {65{p[63]}}) return p[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] t_div(logic signed [63:0] n,
                                                 logic signed [63:0] d);
        if (d == -64'sd1 && n == {1'b1, 63'd0}) return {1'b0, {63{1'b1}}};
        return n / d;
    endfunction

    function automatic logic signed [63:0] sat_w32(logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) return -64'sh8000_0000;
        return x;
    endfunction

    // P' = (P - k*v) / lambda, saturated to 32 bits
    function automatic logic signed [63:0] cov_update(logic signed [63:0] p,
                                                      logic signed [63:0] k,
                                                      logic signed [63:0] v,
                                                      logic signed [63:0] lam);
        logic signed [63:0] t;
        t = s_add(p, -(s_mul(k, v) >>> 16));
        t = t_div(s_mul(t, 64'sd65536), lam);
        return sat_w32(t);
    endfunction

    function automatic void reload_estimates();
        th_a = 64'(m_init_a);
        th_b = 64'(m_init_b);
        p00 = 64'(m_init_cov);
        p01 = 0;
        p11 = 64'(m_init_cov);
        last_speed = 0;
        last_drive = 0;
        primed_ok = 1'b0;
    endfunction

    // One RLS step on an accepted beat; queues the expected result.
    function automatic void predict_rls_step(logic op, logic signed [15:0] spd,
                                             logic signed [15:0] drv);
        logic signed [63:0] w, u, lam, pp0, pp1, den, k0, k1, yh, err, na, nb;
        logic signed [63:0] n00, n01, n11;
        t_est_beat e;
        err = 0;
        e.primed = 1'b0;
        if (op) begin
            reload_estimates();
        end else begin
            w = spd;
            u = drv;
            if (!primed_ok) begin
                primed_ok = 1'b1;
            end else begin
                lam = (m_forget != 0) ? 64'(m_forget) : 64'sd1;
                pp0 = s_add(s_mul(p00, last_speed), s_mul(p01, last_drive)) >>> 8;
                pp1 = s_add(s_mul(p01, last_speed), s_mul(p11, last_drive)) >>> 8;
                den = s_add(lam, s_add(s_mul(last_speed, pp0),
                                       s_mul(last_drive, pp1)) >>> 8);
                if (den == 0) den = 1;
                k0 = t_div(s_mul(pp0, 64'sd65536), den);
                k1 = t_div(s_mul(pp1, 64'sd65536), den);
                yh = s_add(s_mul(th_a, last_speed), s_mul(th_b, last_drive)) >>> 8;
                err = sat_w32(s_add(w <<< 8, -yh));
                na = s_add(th_a, s_mul(k0, err) >>> 16);
                nb = s_add(th_b, s_mul(k1, err) >>> 16);
                // lower bound first, upper bound wins when crossed
                if (na < $signed(64'(m_a_lo))) na = 64'(m_a_lo);
                if (na > $signed(64'(m_a_hi))) na = 64'(m_a_hi);
                if (nb < $signed(64'(m_b_lo))) nb = 64'(m_b_lo);
                if (nb > $signed(64'(m_b_hi))) nb = 64'(m_b_hi);
                th_a = na;
                th_b = nb;
                n00 = cov_update(p00, k0, pp0, lam);
                n11 = cov_update(p11, k1, pp1, lam);
                n01 = cov_update(p01, k0, pp1, lam);
                p00 = n00;
                p11 = n11;
                p01 = n01;
                e.primed = 1'b1;
            end
            last_speed = w;
            last_drive = u;
        end
        e.est_a = th_a[rls_pkg::A_W-1:0];
        e.est_b = th_b[rls_pkg::B_W-1:0];
        e.err = err[31:0];
        expected_q.push_back(e);
    endfunction

    // ---- receiver side: random back-pressure ----
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ---- result checker ----
    always @(posedge i_clk) begin
        t_est_beat e;
        if (i_rst_n && o_valid && i_ready) begin
            beats_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: a=%0d b=%0d err=%0d",
                                               o_est_a, o_est_b, o_pred_error);
            end else begin
                e = expected_q.pop_front();
                if (o_primed) updates_seen++;
                if (o_est_a !== e.est_a || o_est_b !== e.est_b ||
                    o_pred_error !== e.err || o_primed !== e.primed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat %0d mismatch: exp a=%0d b=%0d err=%0d primed=%0b,",
                                  " got a=%0d b=%0d err=%0d primed=%0b"},
                                 beats_checked, e.est_a, e.est_b, e.err, e.primed,
                                 o_est_a, o_est_b, o_pred_error, o_primed);
                end
            end
        end
    end

    // ---- watchdog: cycles without any beat on any channel ----
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     stall_cycles, expected_q.size());
            $display("[rls_two_param_estimator] ERROR");
            $finish;
        end
    end

    // ---- shared drivers ----
    task automatic send_beat(logic op, logic signed [15:0] spd, logic signed [15:0] drv);
        i_valid <= 1'b1;
        i_op <= op;
        i_speed <= spd;
        i_drive <= drv;
        do @(posedge i_clk); while (!o_ready);
        predict_rls_step(op, spd, drv);
        if (op) restarts_sent++; else samples_sent++;
        // optional sender gap; valid stays high otherwise
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(rls_pkg::t_cfg_idx idx, logic [rls_pkg::CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rls_pkg::CFG_FORGET: m_forget = data[rls_pkg::FF_W-1:0];
            rls_pkg::CFG_INIT_A: m_init_a = data[rls_pkg::A_W-1:0];
            rls_pkg::CFG_INIT_B: m_init_b = data[rls_pkg::B_W-1:0];
            rls_pkg::CFG_INIT_C: m_init_cov = data[rls_pkg::COVI_W-1:0];
            rls_pkg::CFG_A_LO:   m_a_lo = data[rls_pkg::A_W-1:0];
            rls_pkg::CFG_A_HI:   m_a_hi = data[rls_pkg::A_W-1:0];
            rls_pkg::CFG_B_LO:   m_b_lo = data[rls_pkg::B_W-1:0];
            rls_pkg::CFG_B_HI:   m_b_hi = data[rls_pkg::B_W-1:0];
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(logic [rls_pkg::CFG_DATA_W-1:0] ff,
                                  logic [rls_pkg::CFG_DATA_W-1:0] ia,
                                  logic [rls_pkg::CFG_DATA_W-1:0] ib,
                                  logic [rls_pkg::CFG_DATA_W-1:0] ic,
                                  logic [rls_pkg::CFG_DATA_W-1:0] alo,
                                  logic [rls_pkg::CFG_DATA_W-1:0] ahi,
                                  logic [rls_pkg::CFG_DATA_W-1:0] blo,
                                  logic [rls_pkg::CFG_DATA_W-1:0] bhi);
        write_reg(rls_pkg::CFG_FORGET, ff);
        write_reg(rls_pkg::CFG_INIT_A, ia);
        write_reg(rls_pkg::CFG_INIT_B, ib);
        write_reg(rls_pkg::CFG_INIT_C, ic);
        write_reg(rls_pkg::CFG_A_LO, alo);
        write_reg(rls_pkg::CFG_A_HI, ahi);
        write_reg(rls_pkg::CFG_B_LO, blo);
        write_reg(rls_pkg::CFG_B_HI, bhi);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(5))
            0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1:       return 16'($urandom);
            2:       return 16'sd0;
            default: return 16'($signed($urandom_range(1024)) - 512);
        endcase
    endfunction

    // ---- tests ----
    // reset defaults, priming, sample extremes, restart ignoring its samples
    task automatic test_directed_extremes();
        send_beat(1'b0, 16'sh0100, 16'sh0080);      // priming only
        send_beat(1'b0, 16'sh7FFF, 16'sh7FFF);
        send_beat(1'b0, 16'sh8000, 16'sh8000);
        send_beat(1'b0, 16'sh7FFF, 16'sh8000);
        send_beat(1'b0, 16'sd0, 16'sd0);
        send_beat(1'b0, 16'sh0200, 16'sh0100);      // zero regressor step
        send_beat(1'b1, 16'sh7FFF, 16'sh8000);      // restart, samples ignored
        send_beat(1'b0, 16'shFFFF, 16'sh0001);
        send_beat(1'b0, 16'sh0001, 16'shFFFF);
        send_beat(1'b1, 16'sd0, 16'sd0);
        send_beat(1'b1, 16'sd0, 16'sd0);            // back-to-back restart
    endtask

    // init_* wait for restart, zero lambda, crossed bounds, register extremes
    task automatic test_register_corners();
        write_all_regs(32'd0, 32'd262144, 32'd1048576, 32'h7FFF_FFFF,
                       32'd200000, 32'd100, 32'd900000, 32'd5);
        send_beat(1'b0, 16'sh0300, 16'sh0100);      // still old init values
        send_beat(1'b0, 16'sh0310, 16'sh0120);
        send_beat(1'b1, 16'sd0, 16'sd0);            // pick up new init values
        send_beat(1'b0, 16'sh0400, 16'shFF00);
        send_beat(1'b0, 16'sh7FFF, 16'sh8000);
        send_beat(1'b0, 16'sh8000, 16'sh7FFF);
        write_all_regs(32'd65536, 32'd0, 32'd0, 32'd0,
                       32'd0, 32'd262144, 32'd0, 32'd1048576);
        send_beat(1'b1, 16'sd0, 16'sd0);
        send_beat(1'b0, 16'sh0100, 16'sh0100);
        send_beat(1'b0, 16'sh0200, 16'sh0100);      // zero covariance: no gain
        write_all_regs(32'h1_FFFF, 32'h7_FFFF, 32'h1F_FFFF, 32'h7FFF_FFFF,
                       32'h7_FFFF, 32'h7_FFFF, 32'h1F_FFFF, 32'h1F_FFFF);
        send_beat(1'b1, 16'sd0, 16'sd0);
        send_beat(1'b0, 16'sh8000, 16'sh8000);
        send_beat(1'b0, 16'sh7FFF, 16'sh7FFF);
    endtask

    // mostly runs of samples with an occasional restart; a few register
    // changes between bursts and one full drain in the middle
    task automatic test_random_phase(int n_items, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) drain_results();
            if (i % 45 == 44) begin
                write_reg(rls_pkg::CFG_FORGET, $urandom_range(65536, 32768));
                write_reg(rls_pkg::CFG_A_LO, $urandom_range(131072));
                write_reg(rls_pkg::CFG_A_HI, $urandom_range(262144, 65536));
                write_reg(rls_pkg::CFG_B_LO, $urandom_range(262144));
                write_reg(rls_pkg::CFG_B_HI, $urandom_range(1048576, 131072));
                write_reg(rls_pkg::CFG_INIT_A, $urandom_range(262144));
                write_reg(rls_pkg::CFG_INIT_B, $urandom_range(1048576));
                write_reg(rls_pkg::CFG_INIT_C,
                          $urandom_range(1) ? $urandom_range(32'h7FFF_FFFF)
                                            : $urandom_range(65536000));
            end
            send_beat($urandom_range(99) < 6, pick_sample(), pick_sample());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = 1'b0;
        i_speed = '0;
        i_drive = '0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        stall_cycles = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        mismatches = 0;
        beats_checked = 0;
        samples_sent = 0;
        restarts_sent = 0;
        updates_seen = 0;
        m_forget = rls_pkg::RST_FF;
        m_init_a = rls_pkg::RST_IA;
        m_init_b = rls_pkg::RST_IB;
        m_init_cov = rls_pkg::RST_IC;
        m_a_lo = rls_pkg::RST_ALO;
        m_a_hi = rls_pkg::RST_AHI;
        m_b_lo = rls_pkg::RST_BLO;
        m_b_hi = rls_pkg::RST_BHI;
        reload_estimates();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 24;
        rx_idle_pct = 63;
        test_directed_extremes();
        test_register_corners();
        write_all_regs(rls_pkg::RST_FF, rls_pkg::RST_IA, rls_pkg::RST_IB, rls_pkg::RST_IC,
                       rls_pkg::RST_ALO, rls_pkg::RST_AHI, rls_pkg::RST_BLO,
                       rls_pkg::RST_BHI);
        send_beat(1'b1, 16'sd0, 16'sd0);
        test_random_phase(135, 24, 63);
        test_random_phase(135, 63, 24);
        test_random_phase(135, 0, 0);

        drain_results();
        repeat (50) @(posedge i_clk);
        $display("covered %0d samples, %0d restarts, %0d register sets; %0d results checked",
                 samples_sent, restarts_sent, 3, beats_checked);
        $display("%0d estimate updates, %0d mismatches", updates_seen, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("[rls_two_param_estimator] OK");
        else
            $display("[rls_two_param_estimator] ERROR");
        $finish;
    end

endmodule

### rls_two_param_estimator.f
design/rls_pkg.sv
design/rls_mul.sv
design/rls_div.sv
design/rls_two_param_estimator.sv
test/tb.sv
